// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: beat payloads,
// command kinds, character codes and sweep control.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Geometry defaults
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Fixed field widths
  localparam int KIND_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = ATTR_W + CHAR_W;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Character codes and attribute reset
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h1F;

  // Input beat
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } tcw_in_t;

  // Result beat
  typedef struct packed {
    logic [CELL_W-1:0]    cell_data;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
  } tcw_out_t;

  // Sweep unit control
  typedef struct packed {
    logic load;
    logic step;
  } tcw_sweep_ctl_t;

endpackage : tcw_pkg

`default_nettype wire

// ===== rtl/core/text_console_writer_unit.sv =====
// Sequence: a put writes at accept, or in S_PUT after a line wrap; a clear
//   blanks every cell; a scroll moves the store up a line, blanks the
//   bottom row, then writes the character if one follows the scroll.
// Throughput: one item at a time, in_ready high only while idle: clear and
//   scroll stall for the one-cell-a-cycle sweep.
// Reset: cursor homed, attribute 31, screen store undefined until first clear.
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console: screen store of attribute/character cells with a cursor,
// put, clear and read commands, line wrap and one-line scroll.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire tcw_pkg::tcw_in_t         in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output tcw_pkg::tcw_out_t             out_data,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [tcw_pkg::ATTR_W-1:0] cfg_data
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);

  localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ADDR_ROW1  = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] ADDR_LROW  = ADDR_W'(COLUMNS * (ROWS - 1));

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PUT    = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_STAIL  = 3'd3;
  localparam logic [2:0] S_BLANK  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ATTR_W-1:0] attr_r;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [CHAR_W-1:0] code_r, code_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] wa_r, wa_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcw_out_t          out_r, out_nxt;

  logic              accept;
  logic              is_nl;
  logic              idx_ok;
  logic [ADDR_W-1:0] pos;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  tcw_sweep_ctl_t    sw_ctl;
  logic [ADDR_W-1:0] sw_first, sw_last_addr, sw_addr;
  logic              sw_last;

  // Configuration: always ready, idle-only by contract
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_valid) begin
      attr_r <= cfg_data;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_nl    = (in_data.char_code == NEWLINE_CODE);
  assign idx_ok   = (32'(in_data.cell_index) < CELL_COUNT);
  assign pos      = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    kind_nxt      = kind_r;
    code_nxt      = code_r;
    rd_ok_nxt     = rd_ok_r;
    pend_nxt      = pend_r;
    wa_nxt        = wa_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = pos;
    mem_wdata     = {attr_r, code_r};
    mem_re        = 1'b0;
    mem_raddr     = sw_addr;
    sw_ctl        = '0;
    sw_first      = '0;
    sw_last_addr  = ADDR_LAST;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt  = in_data.kind;
          code_nxt  = in_data.char_code;
          rd_ok_nxt = (in_data.kind == KIND_READ) && idx_ok;
          state_nxt = S_DONE;
          case (in_data.kind)
            KIND_PUT: begin
              if ((col_r == COL_LAST) || is_nl) begin
                col_nxt = '0;
                if (row_r != ROW_LAST) begin
                  row_nxt   = row_r + ROW_W'(1);
                  state_nxt = is_nl ? S_DONE : S_PUT;
                end else begin
                  // bottom row: scroll up one line first
                  sw_ctl.load = 1'b1;
                  sw_first    = ADDR_ROW1;
                  pend_nxt    = 1'b0;
                  state_nxt   = S_SCROLL;
                end
              end else begin
                mem_we    = 1'b1;
                mem_wdata = {attr_r, in_data.char_code};
                col_nxt   = col_r + COL_W'(1);
              end
            end
            KIND_CLEAR: begin
              col_nxt     = '0;
              row_nxt     = '0;
              sw_ctl.load = 1'b1;
              sw_first    = '0;
              state_nxt   = S_BLANK;
            end
            KIND_READ: begin
              mem_re    = idx_ok;
              mem_raddr = ADDR_W'(in_data.cell_index);
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        col_nxt   = col_r + COL_W'(1);
        state_nxt = S_DONE;
      end

      // read one line down, write the cell read last cycle one line up
      S_SCROLL: begin
        mem_re      = 1'b1;
        sw_ctl.step = 1'b1;
        mem_we      = pend_r;
        mem_waddr   = wa_r;
        mem_wdata   = mem_rdata;
        wa_nxt      = sw_addr - ADDR_ROW1;
        pend_nxt    = 1'b1;
        if (sw_last) begin
          state_nxt = S_STAIL;
        end
      end

      // last moved cell, then sweep the bottom row
      S_STAIL: begin
        mem_we      = 1'b1;
        mem_waddr   = wa_r;
        mem_wdata   = mem_rdata;
        pend_nxt    = 1'b0;
        sw_ctl.load = 1'b1;
        sw_first    = ADDR_LROW;
        state_nxt   = S_BLANK;
      end

      S_BLANK: begin
        mem_we      = 1'b1;
        mem_waddr   = sw_addr;
        mem_wdata   = {attr_r, BLANK_CODE};
        sw_ctl.step = 1'b1;
        if (sw_last) begin
          state_nxt = ((kind_r == KIND_PUT) && (code_r != NEWLINE_CODE)) ? S_PUT : S_DONE;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_nxt.cell_data  = rd_ok_r ? mem_rdata : '0;
          out_nxt.cursor_col = COL_OUT_W'(col_r);
          out_nxt.cursor_row = ROW_OUT_W'(row_r);
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      rd_ok_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      rd_ok_r     <= rd_ok_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    code_r <= code_nxt;
    wa_r   <= wa_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  tcw_sweep_unit #(
    .ADDR_W (ADDR_W)
  ) u_sweep (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (sw_ctl),
    .first_addr (sw_first),
    .last_addr  (sw_last_addr),
    .addr       (sw_addr),
    .last       (sw_last)
  );

  tcw_screen_mem #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule : text_console_writer_unit

`default_nettype wire

// ===== rtl/core/tcw_screen_mem.sv =====
// ----------------------------------------------------------------------------
// tcw_screen_mem
// Screen store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_screen_mem #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ADDR_W-1:0]         waddr,
  input  wire logic [tcw_pkg::CELL_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [ADDR_W-1:0]         raddr,
  output logic      [tcw_pkg::CELL_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule : tcw_screen_mem

`default_nettype wire

// ===== rtl/core/tcw_sweep_unit.sv =====
// ----------------------------------------------------------------------------
// tcw_sweep_unit
// Shared address counter: loads a first and last address, steps by one and
// flags the last address. Drives the clear, scroll and blank-row sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_sweep_unit #(
  parameter int ADDR_W = 11
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire tcw_pkg::tcw_sweep_ctl_t ctl,
  input  wire logic [ADDR_W-1:0]      first_addr,
  input  wire logic [ADDR_W-1:0]      last_addr,
  output logic      [ADDR_W-1:0]      addr,
  output logic                        last
);
  import tcw_pkg::*;

  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] end_r, end_nxt;

  // Load or step
  always_comb begin
    cnt_nxt = cnt_r;
    end_nxt = end_r;
    if (ctl.load) begin
      cnt_nxt = first_addr;
      end_nxt = last_addr;
    end else if (ctl.step) begin
      cnt_nxt = cnt_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      end_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      end_r <= end_nxt;
    end
  end

  assign addr = cnt_r;
  assign last = (cnt_r == end_r);

endmodule : tcw_sweep_unit

`default_nettype wire

// ===== rtl/core/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire tcw_pkg::tcw_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire tcw_pkg::tcw_out_t out_data
);
  import tcw_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // a clear sweeps the whole store, so the block stays busy during the sweep
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.kind == KIND_CLEAR) |=> ##1 !in_ready)
    else $error("clear finished too early");

  // reported cursor column stays on the screen
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.cursor_col) < COLUMNS))
    else $error("cursor column off screen");

endmodule : tcw_checker

bind text_console_writer_unit tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/text_console_checker.sv =====
// ----------------------------------------------------------------------------
// text_console_checker
// Watches the command, result and attribute channels of the text console
// writer. Keeps its own copy of the screen, cursor and attribute, works out
// the result beat due for every accepted command and compares each result
// beat field by field against the oldest one outstanding.
// ----------------------------------------------------------------------------
module text_console_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  tcw_pkg::tcw_in_t             in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  tcw_pkg::tcw_out_t            out_data,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0]   cfg_data,
  input  logic                         drain_done,
  output int unsigned                  pending,
  output int unsigned                  error_count,
  output int unsigned                  scroll_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  // Shadow copy of the console
  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [ATTR_W-1:0] attr;

  tcw_out_t    due_results[$];
  int unsigned result_beats;
  bit          drain_seen;

  // One line per failure, and count it
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] seen);
    $display("[%0t] result beat %0d: %s: expected 0x%0h, got 0x%0h",
             $realtime, result_beats, what, want, seen);
    error_count++;
  endtask

  // Apply one command to the shadow console and build the result it gives
  task automatic run_command(input tcw_in_t cmd, output tcw_out_t res);
    int unsigned pos;
    res = '0;
    case (cmd.kind)
      KIND_PUT: begin
        // newline or standing on the last column: go to the next line
        if (cur_col == COLUMNS - 1 || cmd.char_code == NEWLINE_CODE) begin
          if (cur_row >= ROWS - 1) begin
            // bottom row: move everything up one line, blank the last
            for (int k = 0; k < CELLS - COLUMNS; k++) screen[k] = screen[k + COLUMNS];
            for (int k = CELLS - COLUMNS; k < CELLS; k++) screen[k] = {attr, BLANK_CODE};
            cur_row = ROWS - 1;
            scroll_count++;
          end else begin
            cur_row++;
          end
          cur_col = 0;
        end
        if (cmd.char_code != NEWLINE_CODE) begin
          pos = cur_col + cur_row * COLUMNS;
          if (pos < CELLS) screen[pos] = {attr, cmd.char_code};
          cur_col++;
        end
      end
      KIND_CLEAR: begin
        for (int k = 0; k < CELLS; k++) screen[k] = {attr, BLANK_CODE};
        cur_col = 0;
        cur_row = 0;
      end
      KIND_READ: begin
        if (cmd.cell_index < CELLS) res.cell_data = screen[cmd.cell_index];
      end
      default: ;  // unused kind: nothing moves
    endcase
    res.cursor_col = COL_OUT_W'(cur_col);
    res.cursor_row = ROW_OUT_W'(cur_row);
  endtask

  // Channel monitor: results first, then attribute writes, then commands
  always @(posedge clk) begin
    tcw_out_t due;
    if (!rst_n) begin
      due_results.delete();
      cur_col    = 0;
      cur_row    = 0;
      attr       = ATTR_RESET;
      drain_seen = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", '0, 32'(out_data));
        end else begin
          due = due_results.pop_front();
          if (out_data.cell_data !== due.cell_data)
            report_mismatch("cell_data", 32'(due.cell_data), 32'(out_data.cell_data));
          if (out_data.cursor_col !== due.cursor_col)
            report_mismatch("cursor_col", 32'(due.cursor_col), 32'(out_data.cursor_col));
          if (out_data.cursor_row !== due.cursor_row)
            report_mismatch("cursor_row", 32'(due.cursor_row), 32'(out_data.cursor_row));
        end
        result_beats++;
      end
      if (cfg_valid && cfg_ready) attr = cfg_data;
      if (in_valid && in_ready) begin
        run_command(in_data, due);
        due_results.push_back(due);
      end
      // end of run: anything still outstanding never arrived
      if (drain_done && !drain_seen) begin
        drain_seen = 1'b1;
        if (due_results.size() != 0)
          report_mismatch("results never delivered", '0, 32'(due_results.size()));
      end
    end
    pending <= due_results.size();
  end

endmodule : text_console_checker

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the text console writer with a directed opening (field extremes,
// every command kind, out-of-range reads, attribute extremes) and then
// random text episodes with varied line lengths, reads and clears, under
// three sender/receiver idling mixes. The checker beside the block does the
// predicting and comparing; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLUMNS         = COLUMNS_DEF;
  localparam int ROWS            = ROWS_DEF;
  localparam int CELLS           = COLUMNS * ROWS;
  localparam int ITEMS_PER_PHASE = 634;
  localparam int DRAIN_LIMIT     = 100000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  tcw_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  tcw_out_t          out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ATTR_W-1:0] cfg_data  = '0;
  logic              drain_done = 1'b0;

  int unsigned pending;
  int unsigned error_count;
  int unsigned scroll_count;

  // Stimulus bookkeeping
  int unsigned tx_idle_pct = 28;
  int unsigned rx_idle_pct = 61;
  int unsigned phase_items;
  int unsigned put_count, newline_count, clear_count, read_count, unused_count;
  int unsigned cfg_writes;
  bit          screen_cleared;
  logic [COL_OUT_W-1:0] last_col = '0;
  logic [ROW_OUT_W-1:0] last_row = '0;

  text_console_writer_unit #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  text_console_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .drain_done   (drain_done),
    .pending      (pending),
    .error_count  (error_count),
    .scroll_count (scroll_count)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Track the cursor as the block reports it, for reads near fresh text
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      last_col <= out_data.cursor_col;
      last_row <= out_data.cursor_row;
    end
  end

  // One command beat, with random sender gaps in front of it
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] code,
                           input logic [IDX_W-1:0] index);
    tcw_in_t beat;
    beat.kind       = kind;
    beat.char_code  = code;
    beat.cell_index = index;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    case (kind)
      KIND_PUT: begin
        put_count++;
        if (code == NEWLINE_CODE) newline_count++;
      end
      KIND_CLEAR: begin
        clear_count++;
        screen_cleared = 1'b1;
      end
      KIND_READ: read_count++;
      default:   unused_count++;
    endcase
    if (kind != KIND_UNUSED) phase_items++;
  endtask

  // Hold off until every result is back and the block has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Attribute register write, only with the block idle
  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned nl_pct;
    int unsigned episode_len;
    int unsigned r;
    int          base;
    logic [IDX_W-1:0] idx;
    logic [CHAR_W-1:0] code;

    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: text before any clear, unused kind, clear, edge reads
    send_item(KIND_PUT, 8'h48, 11'h000);
    send_item(KIND_PUT, NEWLINE_CODE, 11'h7FF);
    send_item(KIND_UNUSED, 8'hFF, 11'h7FF);
    send_item(KIND_UNUSED, 8'h00, 11'h000);
    send_item(KIND_CLEAR, 8'h00, 11'h000);
    send_item(KIND_READ, 8'h00, 11'd0);
    send_item(KIND_READ, 8'hFF, IDX_W'(CELLS - 1));
    send_item(KIND_READ, 8'h00, IDX_W'(CELLS));
    send_item(KIND_READ, 8'h00, 11'h7FF);
    send_item(KIND_PUT, 8'h00, 11'h7FF);
    send_item(KIND_PUT, 8'hFF, 11'h000);
    send_item(KIND_PUT, NEWLINE_CODE, 11'h000);
    send_item(KIND_PUT, 8'h7E, 11'h000);
    send_item(KIND_READ, 8'h00, 11'd0);
    send_item(KIND_READ, 8'h00, 11'd1);
    send_item(KIND_READ, 8'h00, IDX_W'(COLUMNS));
    // attribute extremes
    write_attribute(8'h00);
    send_item(KIND_PUT, 8'h78, 11'h000);
    send_item(KIND_READ, 8'h00, IDX_W'(COLUMNS + 1));
    write_attribute(8'hFF);
    send_item(KIND_CLEAR, 8'h00, 11'h000);
    send_item(KIND_READ, 8'h00, 11'd1234);
    send_item(KIND_READ, 8'h00, IDX_W'(CELLS - 1));

    // Random text episodes under three idling mixes
    for (int ph = 0; ph < 3; ph++) begin
      wait_idle();
      tx_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 61 : 0;
      rx_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 28 : 0;
      write_attribute((ph == 0) ? 8'h07 : (ph == 1) ? 8'h80 : ATTR_RESET);
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        // long lines that wrap, medium lines, or short lines that scroll a lot
        r           = $urandom_range(2);
        nl_pct      = (r == 0) ? 1 : (r == 1) ? 6 : 30;
        episode_len = $urandom_range(150, 20);
        if ($urandom_range(7) == 0) send_item(KIND_CLEAR, 8'(urandom_byte()), 11'(idx_noise()));
        if ($urandom_range(7) == 0) wait_idle();
        if ($urandom_range(9) == 0) write_attribute(8'($urandom_range(255)));
        for (int i = 0; i < episode_len && phase_items < ITEMS_PER_PHASE; i++) begin
          r    = $urandom_range(99);
          code = 8'($urandom_range(255));
          if (r < 3) begin
            send_item(KIND_UNUSED, code, 11'($urandom_range(2047)));
          end else if (r < 22 && screen_cleared) begin
            // reads: some just behind the cursor, more anywhere, a few out of range
            r = $urandom_range(9);
            if (r == 0) begin
              idx = 11'($urandom_range(2047, CELLS));
            end else if (r < 5) begin
              base = int'(last_row) * COLUMNS + int'(last_col);
              if (base > CELLS - 1) base = CELLS - 1;
              idx = 11'(base - int'($urandom_range((base > 3) ? 3 : base, 0)));
            end else begin
              idx = 11'($urandom_range(CELLS - 1));
            end
            send_item(KIND_READ, code, idx);
          end else begin
            if ($urandom_range(99) < nl_pct) code = NEWLINE_CODE;
            send_item(KIND_PUT, code, 11'($urandom_range(2047)));
          end
        end
      end
    end
    in_valid <= 1'b0;

    // Drain, then let any sweep finish
    @(posedge clk);
    for (int w = 0; w < DRAIN_LIMIT && pending != 0; w++) @(posedge clk);
    repeat (CELLS + 8) @(posedge clk);
    drain_done <= 1'b1;
    repeat (3) @(posedge clk);

    $display("Covered %0d puts (%0d newlines), %0d clears, %0d reads, %0d unused-kind beats",
             put_count, newline_count, clear_count, read_count, unused_count);
    $display("with %0d scrolls and %0d attribute writes over three idling mixes",
             scroll_count, cfg_writes);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Random byte and index for fields the command ignores
  function automatic int unsigned urandom_byte();
    return $urandom_range(255);
  endfunction

  function automatic int unsigned idx_noise();
    return $urandom_range(2047);
  endfunction

  // Hard stop well beyond the slowest correct run
  initial begin
    #200_000_000;
    $display("Simulation time limit reached");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule : testbench
